[hw/rtl/usct_pkg.sv]
`default_nettype none
package usct_pkg;

  // Counts above this are rejected as bad requests
  localparam int unsigned MAX_DIVISIONS = 1024;
  // Depth of the cell queue between front and back
  localparam int unsigned QUEUE_DEPTH   = 4;
  localparam int unsigned QPTR_W        = $clog2(QUEUE_DEPTH);

  localparam int unsigned COUNT_W  = 11;
  localparam int unsigned INDEX_W  = 10;
  localparam int unsigned COORD_W  = 32;
  localparam int unsigned RADIUS_W = 31;
  localparam int unsigned PHASE_W  = 32;
  localparam int unsigned DIVS_W   = COUNT_W + 1;
  localparam int unsigned ADDR_W   = 5;

  localparam logic [PHASE_W-1:0] QUARTER_TURN = 32'h4000_0000;
  localparam logic signed [31:0] ONE_Q30      = 32'sh4000_0000;
  localparam logic signed [31:0] MINUS_ONE_Q30 = -32'sh4000_0000;

  // Register map, word index
  typedef enum logic [2:0] {
    REG_CENTER_X  = 3'd0,
    REG_CENTER_Y  = 3'd1,
    REG_CENTER_Z  = 3'd2,
    REG_RADIUS    = 3'd3,
    REG_SLICE_CNT = 3'd4,
    REG_RING_CNT  = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] center_x;
    logic signed [COORD_W-1:0] center_y;
    logic signed [COORD_W-1:0] center_z;
    logic [RADIUS_W-1:0]       radius;
    logic [COUNT_W-1:0]        slices;
    logic [COUNT_W-1:0]        rings;
  } cfg_t;

  typedef struct packed {
    logic               bad;
    logic [INDEX_W-1:0] ring;
    logic [INDEX_W-1:0] slice;
  } cell_item_t;

  typedef struct packed {
    logic               start;
    logic [PHASE_W-1:0] phase;
  } trig_req_t;

  typedef struct packed {
    logic               done;
    logic signed [31:0] value;
  } trig_rsp_t;

  typedef enum logic [1:0] {
    TG_IDLE,
    TG_MUL,
    TG_ACC
  } trig_state_t;

  typedef enum logic [3:0] {
    BK_IDLE,
    BK_BAD,
    BK_DIV,
    BK_TGO,
    BK_TWAIT,
    BK_DMUL,
    BK_DACC,
    BK_CMUL,
    BK_CACC,
    BK_EMIT_A,
    BK_EMIT_B
  } back_state_t;

  // Quarter-wave sine polynomial, odd terms, Q30
  function automatic logic signed [31:0] sin_coef(input logic [2:0] k);
    logic signed [31:0] c;
    case (k)
      3'd0: c = 32'sd1686629713;
      3'd1: c = -32'sd693598668;
      3'd2: c = 32'sd85569306;
      3'd3: c = -32'sd5026995;
      3'd4: c = 32'sd172272;
      3'd5: c = -32'sd3864;
      default: c = '0;
    endcase
    return c;
  endfunction

  // Quarter-wave cosine polynomial, even terms, Q30
  function automatic logic signed [31:0] cos_coef(input logic [2:0] k);
    logic signed [31:0] c;
    case (k)
      3'd0: c = 32'sd1073741824;
      3'd1: c = -32'sd1324675879;
      3'd2: c = 32'sd272375560;
      3'd3: c = -32'sd22401992;
      3'd4: c = 32'sd987048;
      3'd5: c = -32'sd27060;
      3'd6: c = 32'sd506;
      default: c = '0;
    endcase
    return c;
  endfunction

  // Q30 rescale of a full product, rounding halves upward
  function automatic logic signed [33:0] mulq(input logic signed [63:0] p);
    logic signed [63:0] s;
    s = p + 64'sd536870912;
    return s[63:30];
  endfunction

endpackage
`default_nettype wire

[hw/rtl/uv_sphere_cell_tessellator_unit.sv]
`default_nettype none
// Tessellates one cell (ring, slice) of a latitude/longitude sphere into at most two
// triangles, vertices in signed Q16.16. A four-entry cell queue takes items at one per
// cycle while not full, also while the back end works; the back end handles one cell at
// a time: phase division, eight sine/cosine evaluations on the polynomial unit, then 20
// multiplies on the vertex multiplier, then the triangles are sent. Those two
// multipliers set the rate. Bad counts or indices give one result with bad_request set
// and zero vertices; a cell whose triangles both collapse gives no result. Registers must
// be written over the APB port only while idle; the block itself does not enforce it.
module uv_sphere_cell_tessellator_unit import usct_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [ADDR_W-1:0]  paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [INDEX_W-1:0] in_ring_index,
  input  wire logic [INDEX_W-1:0] in_slice_index,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [31:0]      out_v0_x,
  output logic signed [31:0]      out_v0_y,
  output logic signed [31:0]      out_v0_z,
  output logic signed [31:0]      out_v1_x,
  output logic signed [31:0]      out_v1_y,
  output logic signed [31:0]      out_v1_z,
  output logic signed [31:0]      out_v2_x,
  output logic signed [31:0]      out_v2_y,
  output logic signed [31:0]      out_v2_z,
  output logic                    out_is_last,
  output logic                    out_bad_request
);

  cfg_t        cfg_r;
  reg_idx_t    reg_idx;
  logic        q_valid, q_pop;
  cell_item_t  q_item;
  trig_req_t   treq;
  trig_rsp_t   trsp;
  logic signed [COORD_W-1:0] bk_v [3][3];

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[4:2]);

  // Register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.center_x <= '0;
      cfg_r.center_y <= '0;
      cfg_r.center_z <= '0;
      cfg_r.radius   <= RADIUS_W'(65536);
      cfg_r.slices   <= COUNT_W'(16);
      cfg_r.rings    <= COUNT_W'(8);
    end else if (psel && penable && pwrite) begin
      case (reg_idx)
        REG_CENTER_X:  cfg_r.center_x <= pwdata;
        REG_CENTER_Y:  cfg_r.center_y <= pwdata;
        REG_CENTER_Z:  cfg_r.center_z <= pwdata;
        REG_RADIUS:    cfg_r.radius   <= pwdata[RADIUS_W-1:0];
        REG_SLICE_CNT: cfg_r.slices   <= pwdata[COUNT_W-1:0];
        REG_RING_CNT:  cfg_r.rings    <= pwdata[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Register reads
  always_comb begin
    case (reg_idx)
      REG_CENTER_X:  prdata = cfg_r.center_x;
      REG_CENTER_Y:  prdata = cfg_r.center_y;
      REG_CENTER_Z:  prdata = cfg_r.center_z;
      REG_RADIUS:    prdata = {1'b0, cfg_r.radius};
      REG_SLICE_CNT: prdata = 32'(cfg_r.slices);
      REG_RING_CNT:  prdata = 32'(cfg_r.rings);
      default:       prdata = '0;
    endcase
  end

  usct_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_ring_index  (in_ring_index),
    .in_slice_index (in_slice_index),
    .cfg            (cfg_r),
    .q_valid        (q_valid),
    .q_item         (q_item),
    .q_pop          (q_pop)
  );

  usct_trig u_trig (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (treq),
    .rsp   (trsp)
  );

  usct_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .treq      (treq),
    .trsp      (trsp),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_v     (bk_v),
    .out_last  (out_is_last),
    .out_bad   (out_bad_request)
  );

  assign out_v0_x = bk_v[0][0];
  assign out_v0_y = bk_v[0][1];
  assign out_v0_z = bk_v[0][2];
  assign out_v1_x = bk_v[1][0];
  assign out_v1_y = bk_v[1][1];
  assign out_v1_z = bk_v[1][2];
  assign out_v2_x = bk_v[2][0];
  assign out_v2_y = bk_v[2][1];
  assign out_v2_z = bk_v[2][2];

endmodule
`default_nettype wire

[hw/rtl/usct_front.sv]
`default_nettype none
module usct_front import usct_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [INDEX_W-1:0] in_ring_index,
  input  wire logic [INDEX_W-1:0] in_slice_index,
  input  wire cfg_t               cfg,
  output logic                    q_valid,
  output cell_item_t              q_item,
  input  wire logic               q_pop
);

  cell_item_t         q_mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [QPTR_W:0]    count_r;
  logic               full;
  logic               push;
  logic               bad;
  cell_item_t         item;

  // Classify: counts out of range or index outside the mesh
  always_comb begin
    bad = (cfg.rings < COUNT_W'(2)) || (cfg.slices < COUNT_W'(3)) ||
          (cfg.rings > COUNT_W'(MAX_DIVISIONS)) ||
          (cfg.slices > COUNT_W'(MAX_DIVISIONS)) ||
          ({1'b0, in_ring_index} >= cfg.rings) ||
          ({1'b0, in_slice_index} >= cfg.slices);
    item.bad   = bad;
    item.ring  = in_ring_index;
    item.slice = in_slice_index;
  end

  assign full     = (count_r == (QPTR_W+1)'(QUEUE_DEPTH));
  assign in_stall = full;
  assign push     = in_valid && !full;
  assign q_valid  = (count_r != '0);
  assign q_item   = q_mem_r[rd_ptr_r];

  // Queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= item;
    end
  end

  // Queue pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (q_pop) rd_ptr_r <= rd_ptr_r + 1'b1;
      if (push && !q_pop) count_r <= count_r + 1'b1;
      else if (!push && q_pop) count_r <= count_r - 1'b1;
    end
  end

endmodule
`default_nettype wire

[hw/rtl/usct_trig.sv]
`default_nettype none
module usct_trig import usct_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire trig_req_t req,
  output trig_rsp_t      rsp
);

  trig_state_t        state_r, state_nxt;
  logic [1:0]         quad_r;
  logic [29:0]        x_r;
  logic signed [31:0] x2_r;
  logic signed [31:0] acc_r, acc_nxt;
  logic [2:0]         n_r;
  logic signed [63:0] prod_r;
  logic               done_r;
  logic signed [31:0] value_r;
  logic               do_start, do_issue, do_acc, finish;
  logic               odd, last_mul_x;
  logic signed [31:0] x_s, op_a, op_b, coef, clamped;
  logic signed [33:0] r;

  assign odd        = quad_r[0];
  assign last_mul_x = !odd && (n_r == 3'd6);
  assign x_s        = $signed({2'b00, x_r});

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      TG_IDLE: if (req.start) state_nxt = TG_MUL;
      TG_MUL:  state_nxt = TG_ACC;
      TG_ACC:  state_nxt = (n_r == 3'd6) ? TG_IDLE : TG_MUL;
      default: state_nxt = TG_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    do_start = 1'b0;
    do_issue = 1'b0;
    do_acc   = 1'b0;
    finish   = 1'b0;
    case (state_r)
      TG_IDLE: do_start = req.start;
      TG_MUL:  do_issue = 1'b1;
      TG_ACC: begin
        do_acc = 1'b1;
        finish = (n_r == 3'd6);
      end
      default: ;
    endcase
  end

  // Operand select: x*x first, then Horner on x^2, sine ends with *x
  always_comb begin
    op_a = (n_r == 3'd0) ? x_s : acc_r;
    op_b = ((n_r == 3'd0) || last_mul_x) ? x_s : x2_r;
    coef = odd ? cos_coef(3'd6 - n_r) : sin_coef(3'd5 - n_r);
    r    = mulq(prod_r);
    if (last_mul_x) acc_nxt = r[31:0];
    else            acc_nxt = coef + r[31:0];
    if (acc_nxt > ONE_Q30)            clamped = ONE_Q30;
    else if (acc_nxt < MINUS_ONE_Q30) clamped = MINUS_ONE_Q30;
    else                              clamped = acc_nxt;
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (do_start) begin
      quad_r <= req.phase[31:30];
      x_r    <= req.phase[29:0];
      acc_r  <= req.phase[30] ? cos_coef(3'd6) : sin_coef(3'd5);
    end
    if (do_issue) prod_r <= op_a * op_b;
    if (do_acc) begin
      if (n_r == 3'd0) x2_r  <= r[31:0];
      else             acc_r <= acc_nxt;
    end
    if (finish) value_r <= quad_r[1] ? -clamped : clamped;
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= TG_IDLE;
      n_r     <= '0;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= finish;
      if (do_start)    n_r <= '0;
      else if (do_acc) n_r <= n_r + 1'b1;
    end
  end

  assign rsp.done  = done_r;
  assign rsp.value = value_r;

endmodule
`default_nettype wire

[hw/rtl/usct_back.sv]
`default_nettype none
module usct_back import usct_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire cfg_t               cfg,
  input  wire logic               q_valid,
  input  wire cell_item_t         q_item,
  output logic                    q_pop,
  output trig_req_t               treq,
  input  wire trig_rsp_t          trsp,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [COORD_W-1:0] out_v [3][3],
  output logic                    out_last,
  output logic                    out_bad
);

  back_state_t        state_r, state_nxt;

  // Phase divider lanes: az(i), az(i+1), pol(j), pol(j+1)
  logic [DIVS_W-1:0]  rem_r [4];
  logic [PHASE_W-1:0] q_r [4];
  logic [DIVS_W-1:0]  rem_nxt [4];
  logic [PHASE_W-1:0] q_nxt [4];
  logic [DIVS_W-1:0]  dn [4];
  logic [COUNT_W-1:0] dk [4];
  logic [1:0]         div_cnt_r;

  logic signed [31:0] trig_r [8];
  logic signed [31:0] dir_r [8];
  logic signed [COORD_W-1:0] vtx_r [4][3];
  logic [2:0]         job_r, dstep_r;
  logic [1:0]         vi_r, ci_r;
  logic signed [63:0] prod_r;
  logic signed [31:0] mul_a, mul_b;
  logic signed [33:0] mq;
  logic signed [34:0] csum;
  logic signed [COORD_W-1:0] center, coord;

  logic signed [COORD_W-1:0] out_v_r [3][3];
  logic               out_valid_r, out_last_r, out_bad_r;
  logic               out_free, eq_ab, eq_cd;

  logic div_init, div_step, trig_start, trig_wr, mul_issue, dacc, cacc;
  logic load_bad, load_a, load_b;

  assign out_free = !out_valid_r || !out_stall;

  // Degenerate edges at the poles
  always_comb begin
    eq_ab = (vtx_r[0][0] == vtx_r[1][0]) && (vtx_r[0][1] == vtx_r[1][1]) &&
            (vtx_r[0][2] == vtx_r[1][2]);
    eq_cd = (vtx_r[2][0] == vtx_r[3][0]) && (vtx_r[2][1] == vtx_r[3][1]) &&
            (vtx_r[2][2] == vtx_r[3][2]);
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE:   if (q_valid) state_nxt = q_item.bad ? BK_BAD : BK_DIV;
      BK_BAD:    if (out_free) state_nxt = BK_IDLE;
      BK_DIV:    if (div_cnt_r == 2'd3) state_nxt = BK_TGO;
      BK_TGO:    state_nxt = BK_TWAIT;
      BK_TWAIT:  if (trsp.done) state_nxt = (job_r == 3'd7) ? BK_DMUL : BK_TGO;
      BK_DMUL:   state_nxt = BK_DACC;
      BK_DACC:   state_nxt = (dstep_r == 3'd7) ? BK_CMUL : BK_DMUL;
      BK_CMUL:   state_nxt = BK_CACC;
      BK_CACC:   state_nxt = (vi_r == 2'd3 && ci_r == 2'd2) ? BK_EMIT_A : BK_CMUL;
      BK_EMIT_A: if (eq_ab || out_free) state_nxt = BK_EMIT_B;
      BK_EMIT_B: if (eq_cd || out_free) state_nxt = BK_IDLE;
      default:   state_nxt = BK_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    q_pop      = 1'b0;
    div_init   = 1'b0;
    div_step   = 1'b0;
    trig_start = 1'b0;
    trig_wr    = 1'b0;
    mul_issue  = 1'b0;
    dacc       = 1'b0;
    cacc       = 1'b0;
    load_bad   = 1'b0;
    load_a     = 1'b0;
    load_b     = 1'b0;
    case (state_r)
      BK_IDLE: begin
        q_pop    = q_valid;
        div_init = q_valid && !q_item.bad;
      end
      BK_BAD:    load_bad   = out_free;
      BK_DIV:    div_step   = 1'b1;
      BK_TGO:    trig_start = 1'b1;
      BK_TWAIT:  trig_wr    = trsp.done;
      BK_DMUL:   mul_issue  = 1'b1;
      BK_DACC:   dacc       = 1'b1;
      BK_CMUL:   mul_issue  = 1'b1;
      BK_CACC:   cacc       = 1'b1;
      BK_EMIT_A: load_a     = !eq_ab && out_free;
      BK_EMIT_B: load_b     = !eq_cd && out_free;
      default: ;
    endcase
  end

  // Divider lane operands
  always_comb begin
    dk[0] = {1'b0, q_item.slice};
    dk[1] = COUNT_W'(q_item.slice) + 1'b1;
    dk[2] = {1'b0, q_item.ring};
    dk[3] = COUNT_W'(q_item.ring) + 1'b1;
    dn[0] = {1'b0, cfg.slices};
    dn[1] = {1'b0, cfg.slices};
    dn[2] = {cfg.rings, 1'b0};
    dn[3] = {cfg.rings, 1'b0};
  end

  // Eight quotient bits per cycle on each lane
  always_comb begin
    logic [DIVS_W:0]    t;
    logic [DIVS_W-1:0]  rr;
    logic [PHASE_W-1:0] qq;
    for (int l = 0; l < 4; l++) begin
      rr = rem_r[l];
      qq = q_r[l];
      for (int s = 0; s < 8; s++) begin
        t = {rr, 1'b0};
        if (t >= {1'b0, dn[l]}) begin
          t  = t - {1'b0, dn[l]};
          qq = {qq[PHASE_W-2:0], 1'b1};
        end else begin
          qq = {qq[PHASE_W-2:0], 1'b0};
        end
        rr = t[DIVS_W-1:0];
      end
      rem_nxt[l] = rr;
      q_nxt[l]   = qq;
    end
  end

  always_ff @(posedge clk) begin
    if (div_init) begin
      for (int l = 0; l < 4; l++) begin
        rem_r[l] <= ({1'b0, dk[l]} == dn[l]) ? '0 : {1'b0, dk[l]};
        q_r[l]   <= '0;
      end
    end else if (div_step) begin
      for (int l = 0; l < 4; l++) begin
        rem_r[l] <= rem_nxt[l];
        q_r[l]   <= q_nxt[l];
      end
    end
  end

  // Trig jobs: cos/sin of both azimuths, sin/cos of both polar angles
  always_comb begin
    treq.start = trig_start;
    treq.phase = q_r[job_r[2:1]] + ((job_r[0] == job_r[2]) ? QUARTER_TURN : '0);
  end

  always_ff @(posedge clk) begin
    if (trig_wr) trig_r[job_r] <= trsp.value;
  end

  // Shared multiplier: direction products, then radius scaling
  always_comb begin
    if (state_r == BK_DMUL) begin
      mul_a = trig_r[{1'b0, dstep_r[1], dstep_r[0]}];
      mul_b = trig_r[{1'b1, dstep_r[2], 1'b0}];
    end else begin
      mul_a = $signed({1'b0, cfg.radius});
      case (ci_r)
        2'd0:    mul_b = dir_r[{vi_r, 1'b0}];
        2'd1:    mul_b = dir_r[{vi_r, 1'b1}];
        default: mul_b = trig_r[{1'b1, vi_r[1], 1'b1}];
      endcase
    end
    mq = mulq(prod_r);
    case (ci_r)
      2'd0:    center = cfg.center_x;
      2'd1:    center = cfg.center_y;
      default: center = cfg.center_z;
    endcase
    csum = 35'(center) + 35'(mq);
    if (csum > 35'sd2147483647)       coord = 32'sh7FFF_FFFF;
    else if (csum < -35'sd2147483648) coord = 32'sh8000_0000;
    else                              coord = csum[31:0];
  end

  always_ff @(posedge clk) begin
    if (mul_issue) prod_r <= mul_a * mul_b;
    if (dacc) dir_r[dstep_r] <= mq[31:0];
    if (cacc) vtx_r[vi_r][ci_r] <= coord;
  end

  // Output register: B,A,C then D,B,C
  always_ff @(posedge clk) begin
    if (load_bad) begin
      for (int a = 0; a < 3; a++)
        for (int c = 0; c < 3; c++)
          out_v_r[a][c] <= '0;
      out_last_r <= 1'b1;
      out_bad_r  <= 1'b1;
    end else if (load_a) begin
      out_v_r[0] <= vtx_r[1];
      out_v_r[1] <= vtx_r[0];
      out_v_r[2] <= vtx_r[2];
      out_last_r <= eq_cd;
      out_bad_r  <= 1'b0;
    end else if (load_b) begin
      out_v_r[0] <= vtx_r[3];
      out_v_r[1] <= vtx_r[1];
      out_v_r[2] <= vtx_r[2];
      out_last_r <= 1'b1;
      out_bad_r  <= 1'b0;
    end
  end

  // Control registers and step counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      div_cnt_r   <= '0;
      job_r       <= '0;
      dstep_r     <= '0;
      vi_r        <= '0;
      ci_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (div_init)      div_cnt_r <= '0;
      else if (div_step) div_cnt_r <= div_cnt_r + 1'b1;
      if (trig_wr) job_r   <= job_r + 1'b1;
      if (dacc)    dstep_r <= dstep_r + 1'b1;
      if (cacc) begin
        if (ci_r == 2'd2) begin
          ci_r <= '0;
          vi_r <= vi_r + 1'b1;
        end else begin
          ci_r <= ci_r + 1'b1;
        end
      end
      if (load_bad || load_a || load_b) out_valid_r <= 1'b1;
      else if (!out_stall)              out_valid_r <= 1'b0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_v     = out_v_r;
  assign out_last  = out_last_r;
  assign out_bad   = out_bad_r;

endmodule
`default_nettype wire

[bench/tb_uv_sphere_cell_tessellator_unit.sv]
module tb_uv_sphere_cell_tessellator_unit;
  import usct_pkg::*;

  localparam int unsigned IDLE_LIMIT = 20000;
  localparam int unsigned DRAIN_CYCLES = 2000;
  localparam int unsigned LONG_HOLD = 4000;

  // quarter-wave polynomial coefficients, Q30
  localparam longint SIN_C [6] = '{1686629713, -693598668, 85569306, -5026995, 172272, -3864};
  localparam longint COS_C [7] = '{1073741824, -1324675879, 272375560, -22401992, 987048,
                                   -27060, 506};

  typedef struct {
    logic [INDEX_W-1:0] ring;
    logic [INDEX_W-1:0] slice;
  } cell_t;

  typedef struct {
    logic signed [31:0] v [9];
    bit                 last;
    bit                 bad;
  } tri_t;

  logic               clk;
  logic               rst_n;
  logic               psel, penable, pwrite;
  logic [ADDR_W-1:0]  paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;
  logic               in_valid;
  logic               in_stall;
  logic [INDEX_W-1:0] in_ring_index, in_slice_index;
  logic               out_valid;
  logic               out_stall;
  logic signed [31:0] out_v [9];
  logic               out_is_last, out_bad_request;

  uv_sphere_cell_tessellator_unit u_top (
    .clk(clk), .rst_n(rst_n),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_ring_index(in_ring_index), .in_slice_index(in_slice_index),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_v0_x(out_v[0]), .out_v0_y(out_v[1]), .out_v0_z(out_v[2]),
    .out_v1_x(out_v[3]), .out_v1_y(out_v[4]), .out_v1_z(out_v[5]),
    .out_v2_x(out_v[6]), .out_v2_y(out_v[7]), .out_v2_z(out_v[8]),
    .out_is_last(out_is_last), .out_bad_request(out_bad_request)
  );

  // predictor copy of the registers
  longint      m_cx, m_cy, m_cz, m_rad;
  int unsigned m_slices, m_rings;

  cell_t  cells_pending [$];
  cell_t  cell_on_bus;
  tri_t   tris_expected [$];
  int     err_count;
  int     results_seen;
  bit     in_taken;
  int     idle_cycles;

  // Q30 product, round half up
  function automatic longint q30_mul(longint a, longint b);
    return (a * b + 64'sd536870912) >>> 30;
  endfunction

  function automatic longint sin_of_phase(logic [31:0] ph);
    longint x, x2, acc;
    int k;
    x  = longint'(ph[29:0]);
    x2 = q30_mul(x, x);
    if (!ph[30]) begin
      acc = SIN_C[5];
      for (k = 4; k >= 0; k--) acc = SIN_C[k] + q30_mul(acc, x2);
      acc = q30_mul(acc, x);
    end else begin
      acc = COS_C[6];
      for (k = 5; k >= 0; k--) acc = COS_C[k] + q30_mul(acc, x2);
    end
    if (acc > 64'sd1073741824) acc = 64'sd1073741824;
    if (acc < -64'sd1073741824) acc = -64'sd1073741824;
    return ph[31] ? -acc : acc;
  endfunction

  function automatic logic signed [31:0] sat_coord(longint ctr, longint unit);
    longint v;
    v = ctr + q30_mul(m_rad, unit);
    if (v > 64'sd2147483647) v = 64'sd2147483647;
    if (v < -64'sd2147483648) v = -64'sd2147483648;
    return v[31:0];
  endfunction

  // mesh vertex at azimuth step k, polar step m
  task automatic mesh_vertex(input int unsigned k, input int unsigned m,
                             output logic signed [31:0] p [3]);
    logic [63:0] az, po;
    longint sp;
    az = (64'(k) << 32) / 64'(m_slices);
    po = (64'(m) << 32) / (64'(m_rings) * 2);
    sp = sin_of_phase(po[31:0]);
    p[0] = sat_coord(m_cx, q30_mul(sin_of_phase(az[31:0] + QUARTER_TURN), sp));
    p[1] = sat_coord(m_cy, q30_mul(sin_of_phase(az[31:0]), sp));
    p[2] = sat_coord(m_cz, sin_of_phase(po[31:0] + QUARTER_TURN));
  endtask

  function automatic tri_t make_tri(logic signed [31:0] a [3], logic signed [31:0] b [3],
                                    logic signed [31:0] c [3]);
    tri_t t;
    for (int n = 0; n < 3; n++) begin
      t.v[n] = a[n]; t.v[3+n] = b[n]; t.v[6+n] = c[n];
    end
    t.last = 0;
    t.bad  = 0;
    return t;
  endfunction

  // queue up the triangles one cell produces
  task automatic predict_cell_tris(input cell_t c);
    logic signed [31:0] a [3], b [3], cc [3], d [3];
    tri_t t;
    int unsigned j, i;
    int cnt;
    j = c.ring;
    i = c.slice;
    cnt = 0;
    if (m_rings < 2 || m_slices < 3 || m_rings > MAX_DIVISIONS || m_slices > MAX_DIVISIONS ||
        j >= m_rings || i >= m_slices) begin
      foreach (t.v[n]) t.v[n] = '0;
      t.last = 1;
      t.bad  = 1;
      tris_expected.insert(tris_expected.size(), t);
    end else begin
      mesh_vertex(i, j, a);
      mesh_vertex(i + 1, j, b);
      mesh_vertex(i, j + 1, cc);
      mesh_vertex(i + 1, j + 1, d);
      if (a != b) begin
        tris_expected.insert(tris_expected.size(), make_tri(b, a, cc));
        cnt++;
      end
      if (cc != d) begin
        tris_expected.insert(tris_expected.size(), make_tri(d, b, cc));
        cnt++;
      end
      if (cnt > 0) tris_expected[$].last = 1;
    end
  endtask

  // clock
  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // input driver: bursts and gaps
  int burst_left, gap_left;
  bit send_enable;
  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_taken)) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (send_enable && cells_pending.size() > 0) begin
        cell_on_bus    = cells_pending.pop_front();
        in_valid       <= 1'b1;
        in_ring_index  <= cell_on_bus.ring;
        in_slice_index <= cell_on_bus.slice;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 12);
          case ($urandom_range(0, 3))
            0: gap_left = $urandom_range(100, 400);
            1: gap_left = $urandom_range(1, 8);
            default: gap_left = 0;
          endcase
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver stall pattern, with one long hold-off
  int hold_left, mode_left, stall_mode;
  bit hold_done;
  always @(negedge clk) begin
    if (rst_n) begin
      if (mode_left == 0) begin
        mode_left  = $urandom_range(20, 300);
        stall_mode = $urandom_range(0, 3);
      end else begin
        mode_left--;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (!hold_done && results_seen >= 30) begin
        hold_done = 1;
        hold_left = LONG_HOLD;
        out_stall <= 1'b1;
      end else begin
        case (stall_mode)
          0: out_stall <= 1'b0;
          1: out_stall <= $urandom_range(0, 1);
          2: out_stall <= (mode_left % 4) == 0;
          default: out_stall <= ($urandom_range(0, 7) == 0);
        endcase
      end
    end
  end

  // monitor: predict on accepted cells, check accepted triangles, watchdog
  always @(posedge clk) begin
    tri_t e;
    bit bad_field;
    in_taken = rst_n && in_valid && !in_stall;
    if (in_taken) begin
      cell_t c;
      c.ring  = in_ring_index;
      c.slice = in_slice_index;
      predict_cell_tris(c);
    end
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (tris_expected.size() == 0) begin
        err_count++;
        if (err_count <= 10) $display("unexpected triangle, v0_x=%0d", out_v[0]);
      end else begin
        e = tris_expected.pop_front();
        bad_field = (e.last != out_is_last) || (e.bad != out_bad_request);
        foreach (e.v[n]) if (e.v[n] !== out_v[n]) bad_field = 1;
        if (bad_field) begin
          err_count++;
          if (err_count <= 10) begin
            $display("mismatch: exp v=%p last=%0d bad=%0d", e.v, e.last, e.bad);
            $display("          got v=%p last=%0d bad=%0d", out_v, out_is_last,
                     out_bad_request);
          end
        end
      end
    end
    if (in_taken || (rst_n && out_valid && !out_stall)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic reg_write(input reg_idx_t idx, input logic [31:0] val);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'(idx) << 2;
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_CENTER_X:  m_cx = longint'($signed(val));
      REG_CENTER_Y:  m_cy = longint'($signed(val));
      REG_CENTER_Z:  m_cz = longint'($signed(val));
      REG_RADIUS:    m_rad = longint'(val[30:0]);
      REG_SLICE_CNT: m_slices = val[10:0];
      REG_RING_CNT:  m_rings = val[10:0];
      default: ;
    endcase
  endtask

  task automatic write_all(input logic [31:0] cx, input logic [31:0] cy, input logic [31:0] cz,
                           input logic [31:0] rad, input logic [31:0] sl,
                           input logic [31:0] rg);
    reg_write(REG_CENTER_X, cx);
    reg_write(REG_CENTER_Y, cy);
    reg_write(REG_CENTER_Z, cz);
    reg_write(REG_RADIUS, rad);
    reg_write(REG_SLICE_CNT, sl);
    reg_write(REG_RING_CNT, rg);
  endtask

  task automatic add_cell(input int unsigned r, input int unsigned s);
    cell_t c;
    c.ring  = r[INDEX_W-1:0];
    c.slice = s[INDEX_W-1:0];
    cells_pending.insert(cells_pending.size(), c);
  endtask

  // mostly in-range cells, some raw 10-bit noise
  task automatic add_random_cells(input int n);
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(0, 9) == 0 || m_slices < 1 || m_rings < 1 ||
          m_slices > 1024 || m_rings > 1024)
        add_cell($urandom_range(0, 1023), $urandom_range(0, 1023));
      else
        add_cell($urandom_range(0, m_rings - 1), $urandom_range(0, m_slices - 1));
    end
  endtask

  // let everything drain, then allow for queued cells that emit nothing
  task automatic wait_idle();
    send_enable = 1;
    while (cells_pending.size() > 0 || in_valid || tris_expected.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    rst_n = 0; psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
    in_valid = 0; in_ring_index = '0; in_slice_index = '0; out_stall = 0;
    err_count = 0; results_seen = 0; idle_cycles = 0; send_enable = 0;
    burst_left = 0; gap_left = 0; hold_left = 0; mode_left = 0; hold_done = 0;
    m_cx = 0; m_cy = 0; m_cz = 0; m_rad = 65536; m_slices = 16; m_rings = 8;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    // directed: poles, seam, out-of-range indices, extreme index bits
    write_all(0, 0, 0, 32'd65536, 16, 8);
    add_cell(0, 0); add_cell(7, 15); add_cell(3, 5); add_cell(0, 15); add_cell(7, 0);
    add_cell(8, 0); add_cell(0, 16); add_cell(1023, 1023); add_cell(4, 8);
    wait_idle();
    // saturation at both extremes, minimal valid counts
    write_all(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 3, 2);
    add_cell(0, 0); add_cell(1, 2); add_cell(0, 1); add_cell(1, 0); add_cell(2, 3);
    wait_idle();
    write_all(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 4, 3);
    add_random_cells(40);
    wait_idle();
    // zero radius: every in-range cell collapses
    write_all(32'h0001_0000, 32'hFFFF_0000, 32'h1234_5678, 0, 8, 4);
    add_random_cells(20);
    wait_idle();
    // largest counts
    write_all($urandom, $urandom, $urandom, 32'h0100_0000, 1024, 1024);
    add_cell(1023, 1023); add_cell(0, 0); add_cell(512, 511);
    add_random_cells(60);
    wait_idle();
    // bad counts
    write_all(0, 0, 0, 32'd65536, 2047, 2047);
    add_random_cells(15);
    wait_idle();
    write_all(0, 0, 0, 32'd65536, 0, 0);
    add_random_cells(10);
    wait_idle();
    write_all(0, 0, 0, 32'd65536, 2, 1);
    add_random_cells(10);
    wait_idle();
    write_all(0, 0, 0, 32'd65536, 1025, 1025);
    add_random_cells(10);
    wait_idle();

    // random settings, small counts mostly
    for (int ph = 0; ph < 10; ph++) begin
      logic [31:0] sl, rg;
      sl = (ph == 9) ? $urandom_range(3, 1024) : $urandom_range(3, 40);
      rg = (ph == 8) ? $urandom_range(2, 1024) : $urandom_range(2, 40);
      if (ph == 7) begin
        sl = $urandom_range(0, 2047);
        rg = $urandom_range(0, 2047);
      end
      write_all($urandom_range(0, 1) ? $urandom : $urandom_range(0, 32'h0010_0000),
                $urandom, $urandom_range(0, 1) ? $urandom : 0,
                $urandom_range(0, 1) ? $urandom : $urandom_range(0, 32'h0040_0000), sl, rg);
      add_random_cells(157);
      wait_idle();
    end

    if (err_count == 0 && tris_expected.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

[files.f]
hw/rtl/usct_pkg.sv
hw/rtl/usct_front.sv
hw/rtl/usct_trig.sv
hw/rtl/usct_back.sv
hw/rtl/uv_sphere_cell_tessellator_unit.sv
bench/tb_uv_sphere_cell_tessellator_unit.sv
